@@ rtl/core/assert_macros.svh @@
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset.
`define BOW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bow friction assertion failed");
// Check that a condition never holds on a clock edge outside reset.
`define BOW_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bow friction forbidden condition seen");
`else
`define BOW_ASSERT(label, clk, rst_n, prop)
`define BOW_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/core/bow_ssf_pkg.sv @@
// Shared constants and controller/datapath interface types of the bow friction block.
package bow_ssf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DF_W      = 31;
    localparam int QUO_W     = DF_W;
    localparam int NUM_W     = DF_W + FRAC_BITS;
    localparam int DEN_W     = WORD_W + 1;
    localparam int REM_W     = DEN_W;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [DEN_W-1:0] FIX_ONE = DEN_W'(1) << FRAC_BITS;
    localparam logic [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_BOW_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOW_VELOCITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWNWARD_FORCE = 2'd2;

    typedef struct packed {
        logic load_in;
        logic step;
        logic eval;
        logic div_step;
        logic div_last;
        logic out_load;
    } bow_ssf_cmd_t;

    typedef struct packed {
        logic enable;
        logic slip;
        logic pv_neg;
    } bow_ssf_status_t;

endpackage

@@ rtl/core/bow_ssf_ctrl.sv @@
// Sequencer of the bow friction block: handshakes and divider step count.
module bow_ssf_ctrl
    import bow_ssf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  bow_ssf_status_t status,
    output bow_ssf_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // a word taken while disabled is dropped here
                if (in_valid && status.enable)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                count_next = '0;
                state_next = (status.slip && status.pv_neg) ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(QUO_W - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/bow_ssf_dp.sv @@
// Datapath of the bow friction block: settings, bow state, spring path and serial divider.
module bow_ssf_dp
    import bow_ssf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bow_ssf_cmd_t          cmd,
    output bow_ssf_status_t       status,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    input  logic signed [WORD_W-1:0] point_velocity,
    input  logic signed [WORD_W-1:0] point_position,
    output logic signed [WORD_W-1:0] friction_force,
    output logic                  slipping
);

    logic              en_reg;
    logic [WORD_W-1:0] bv_reg;
    logic [DF_W-1:0]   df_reg;

    logic              slip_reg, slip_next;
    logic [WORD_W-1:0] bp_reg, bp_next;
    logic [WORD_W-1:0] force_reg, force_next;

    logic [WORD_W-1:0] pv_reg, pp_reg;
    logic [WORD_W-1:0] mag_reg;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [WORD_W-1:0] ff_reg;
    logic              sl_reg;

    logic [WORD_W:0]   bp_sum, stick, rel_pos, rel_neg, trial_sub;
    logic [WORD_W-1:0] bp_sat, stick_sat;
    logic              stick_gt;
    logic [NUM_W-1:0]  num;
    logic [REM_W:0]    trial;

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
            bv_reg <= '0;
            df_reg <= DF_W'(FIX_ONE);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOW_ENABLE:     en_reg <= cfg_data[0];
                REG_BOW_VELOCITY:   bv_reg <= cfg_data;
                REG_DOWNWARD_FORCE: df_reg <= cfg_data[DF_W-1:0];
                default:            ;
            endcase
        end
    end

    // saturating bow advance and relative velocity magnitude
    assign bp_sum  = {bp_reg[WORD_W-1], bp_reg} + {bv_reg[WORD_W-1], bv_reg};
    assign bp_sat  = (bp_sum[WORD_W] != bp_sum[WORD_W-1])
                   ? (bp_sum[WORD_W] ? S32_MIN : S32_MAX) : bp_sum[WORD_W-1:0];
    assign rel_pos = {bv_reg[WORD_W-1], bv_reg} - {pv_reg[WORD_W-1], pv_reg};
    assign rel_neg = {pv_reg[WORD_W-1], pv_reg} - {bv_reg[WORD_W-1], bv_reg};

    // spring force and static limit; it never exceeds the limit when stored
    assign stick     = {bp_reg[WORD_W-1], bp_reg} - {pp_reg[WORD_W-1], pp_reg};
    assign stick_gt  = $signed(stick) > $signed({2'b00, df_reg});
    assign stick_sat = (stick[WORD_W] && !stick[WORD_W-1]) ? S32_MIN : stick[WORD_W-1:0];

    assign num = {df_reg, {FRAC_BITS{1'b0}}};

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_sub = trial[REM_W-1:0] - den_reg;

    always_comb
    begin
        slip_next  = slip_reg;
        bp_next    = bp_reg;
        force_next = force_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (cmd.step)
            bp_next = bp_sat;
        if (cmd.eval)
        begin
            if (!slip_reg)
            begin
                if (stick_gt)
                    slip_next = 1'b1;
                else
                    force_next = stick_sat;
            end
            else if (!pv_reg[WORD_W-1])
            begin
                slip_next = 1'b0;
                bp_next   = pp_reg;
            end
            else
            begin
                den_next = FIX_ONE + {1'b0, mag_reg};
                rem_next = REM_W'(num[NUM_W-1:QUO_W]);
                quo_next = num[QUO_W-1:0];
            end
        end
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial_sub[REM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[REM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            if (cmd.div_last)
                force_next = {1'b0, quo_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slip_reg  <= 1'b0;
            bp_reg    <= '0;
            force_reg <= '0;
        end
        else
        begin
            slip_reg  <= slip_next;
            bp_reg    <= bp_next;
            force_reg <= force_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load_in)
        begin
            pv_reg <= point_velocity;
            pp_reg <= point_position;
        end
        if (cmd.step)
            mag_reg <= rel_pos[WORD_W] ? rel_neg[WORD_W-1:0] : rel_pos[WORD_W-1:0];
        if (cmd.out_load)
        begin
            ff_reg <= force_reg;
            sl_reg <= slip_reg;
        end
    end

    assign status.enable  = en_reg;
    assign status.slip    = slip_reg;
    assign status.pv_neg  = pv_reg[WORD_W-1];
    assign friction_force = ff_reg;
    assign slipping       = sl_reg;

endmodule

@@ rtl/core/bow_stick_slip_friction.sv @@
// Sequence per word: accept, advance the bow, evaluate the mode, run the divider only in kinetic
// slip, then load the output register once a stalled word has left it; no new word is taken
// until then. The one-quotient-bit-per-cycle restoring divider (31 steps) gives the slip force.
// A word taken while bow_enable is 0 is dropped and gives no result.
// Reset (rst_n low, asynchronous): stick mode, bow point and force zero, bow disabled,
// bow velocity zero, downward force 1.0; output register empty.
module bow_stick_slip_friction
    import bow_ssf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WORD_W-1:0] point_velocity,
    input  logic signed [WORD_W-1:0] point_position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] friction_force,
    output logic                     slipping
);

`include "assert_macros.svh"

    bow_ssf_cmd_t    cmd;
    bow_ssf_status_t status;

    // Sequencer: take a word, advance the bow, evaluate the mode, run the divider when the bow
    // slides with a negative point velocity, then hand the word to the output register.
    bow_ssf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: settings, bow point, mode, force, divider and output register.
    bow_ssf_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .point_velocity (point_velocity),
        .point_position (point_position),
        .friction_force (friction_force),
        .slipping       (slipping)
    );

    // Only one phase of the sequence acts in a cycle.
    `BOW_ASSERT(a_one_phase, clk, rst_n, $onehot0({cmd.load_in, cmd.step, cmd.eval, cmd.div_step, cmd.out_load}))
    // An accepted word while enabled advances the bow in the next cycle.
    `BOW_ASSERT(a_step_follows, clk, rst_n, (in_valid && !in_stall && status.enable) |=> cmd.step)
    // The final divider step is a divider step.
    `BOW_NEVER(a_last_is_step, clk, rst_n, cmd.div_last && !cmd.div_step)
    // Loading the output register presents a word next cycle.
    `BOW_ASSERT(a_out_shown, clk, rst_n, cmd.out_load |=> out_valid)

endmodule

@@ test/bow_stick_slip_friction_test.sv @@
// Self-checking testbench for the bow stick-slip friction block with random handshakes.
module bow_stick_slip_friction_test;
    import bow_ssf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Pad past the slowest word, a kinetic slip through the divider.
    localparam int  LATENCY_PAD = 40;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  PHASES      = 10;
    localparam int  PHASE_WORDS = 65;

    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam logic signed [WORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] NEG_MAX = 32'sh8000_0000;

    typedef struct {
        logic signed [WORD_W-1:0] fric;
        logic                     slip;
    } fric_t;

    logic                     clk;
    logic                     rst_n          = 1'b0;
    logic                     cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index      = REG_BOW_ENABLE;
    logic [WORD_W-1:0]        cfg_data       = '0;
    logic                     in_valid       = 1'b0;
    logic                     in_stall;
    logic signed [WORD_W-1:0] point_velocity = '0;
    logic signed [WORD_W-1:0] point_position = '0;
    logic                     out_valid;
    logic                     out_stall      = 1'b0;
    logic signed [WORD_W-1:0] friction_force;
    logic                     slipping;

    bow_stick_slip_friction dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .point_velocity (point_velocity),
        .point_position (point_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .friction_force (friction_force),
        .slipping       (slipping)
    );

    // Shadow registers, mirrored on every write.
    logic                     bow_on;
    logic signed [WORD_W-1:0] bow_vel;
    logic [DF_W-1:0]          push_force;

    // Shadow of the bow state, advanced once per accepted word while the bow is on.
    logic                     slip_now;
    logic signed [WORD_W-1:0] bow_pos;
    logic signed [WORD_W-1:0] held_force;

    fric_t  fric_q[$];     // forces and modes still owed by the block
    int     err_count   = 0;
    int     cycle_count = 0;
    int     stall_left  = 0;
    bit     no_idle     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost word lands here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
        if (v > WORD_HI)
            return POS_MAX;
        if (v < WORD_LO)
            return NEG_MAX;
        return v[WORD_W-1:0];
    endfunction

    // One tick of the bow: move the bow point, then either pull like a spring
    // (stick), re-capture the point (slip, point moving forward), or divide the
    // pressing force by the relative speed (slip, kinetic).
    function automatic void advance_bow(input logic signed [WORD_W-1:0] pv,
                                        input logic signed [WORD_W-1:0] pp);
        longint stretch;
        longint rel;
        longint mag;
        longint quo;
        bow_pos = clamp_word(longint'(bow_pos) + longint'(bow_vel));
        if (!slip_now)
        begin
            stretch = longint'(bow_pos) - longint'(pp);
            // Break loose past the static limit; hold the last force.
            if (stretch > longint'(push_force))
                slip_now = 1'b1;
            else
                held_force = clamp_word(stretch);
        end
        else if (pv >= 0)
        begin
            slip_now = 1'b0;
            bow_pos  = pp;
        end
        else
        begin
            rel = longint'(bow_vel) - longint'(pv);
            mag = (rel < 0) ? -rel : rel;
            quo = (longint'(push_force) <<< FRAC_BITS) / ((longint'(1) <<< FRAC_BITS) + mag);
            held_force = quo[WORD_W-1:0];
        end
        fric_q.push_back('{held_force, slip_now});
    endfunction

    // Drop valid and hold until the block has handed back every owed word.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (fric_q.size() != 0)
            @(posedge clk);
    endtask

    // Registers change only with the block idle; a dropped word leaves no
    // trace in the queue, so pad by the worst latency as well.
    task automatic cfg_set(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        wait_results_done();
        repeat (LATENCY_PAD) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_BOW_ENABLE:     bow_on     = data[0];
            REG_BOW_VELOCITY:   bow_vel    = data;
            REG_DOWNWARD_FORCE: push_force = data[DF_W-1:0];
            default:            ;
        endcase
    endtask

    // Offer one word after a random gap; keep valid high across back-to-back words.
    task automatic send_word(input logic signed [WORD_W-1:0] pv,
                             input logic signed [WORD_W-1:0] pp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        point_velocity <= pv;
        point_position <= pp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (bow_on)
            advance_bow(pv, pp);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_velocity();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1, 2, 3: return $urandom_range(0, 1 << 18);
            default: return -$signed({1'b0, 31'($urandom_range(1, 1 << 18))});
        endcase
    endfunction

    // Mostly keep the point within reach of the bow so that stick, break-loose
    // and re-capture all keep happening; the rest is unrestricted noise.
    task automatic shaped_word(output logic signed [WORD_W-1:0] pv,
                               output logic signed [WORD_W-1:0] pp);
        longint span;
        longint offs;
        if ($urandom_range(0, 9) < 3)
        begin
            pv = $urandom;
            pp = $urandom;
        end
        else
        begin
            pv   = pick_velocity();
            span = longint'(push_force) + (longint'(push_force) >>> 2) + 16;
            if (span > 64'sh3FFF_FFFF)
                span = 64'sh3FFF_FFFF;
            offs = longint'($urandom_range(0, 32'(2 * span))) - span;
            pp   = clamp_word(longint'(bow_pos) + longint'(bow_vel) - offs);
        end
    endtask

    // Output side: compare each word with the oldest owed one, then stall at random.
    always @(posedge clk)
    begin : watch_output
        fric_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (fric_q.size() == 0)
                    flag_mismatch($sformatf("word with none owed: force %0d slip %0b",
                                            friction_force, slipping));
                else
                begin
                    want = fric_q.pop_front();
                    if (friction_force !== want.fric)
                        flag_mismatch($sformatf("force %0d, want %0d",
                                                friction_force, want.fric));
                    if (slipping !== want.slip)
                        flag_mismatch($sformatf("slip %0b, want %0b", slipping, want.slip));
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 19);
            end
            else if (stall_left > 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // Disabled bow drops every word; stray enable bits and the spare index change nothing.
    task automatic test_disabled_drop();
        send_word(32'sd100, -32'sd5);
        send_word(NEG_MAX, POS_MAX);
        cfg_set(REG_BOW_ENABLE, 32'hFFFF_FFFE);
        cfg_set(REG_SPARE, 32'hFFFF_FFFF);
        send_word(POS_MAX, NEG_MAX);
        send_word(-32'sd1, -32'sd1);
        cfg_set(REG_BOW_ENABLE, 32'd1);
    endtask

    // Spring force up to the static limit, break-loose, kinetic division,
    // re-capture, and a spring force that overflows in the negative direction.
    task automatic test_stick_slip_edges();
        send_word(32'sd0, 32'sd0);
        send_word(32'sd0, -32'sd65536);
        send_word(32'sd0, -32'sd65537);
        send_word(-32'sd65536, 32'sd7);
        send_word(NEG_MAX, 32'sd0);
        send_word(32'sd0, NEG_MAX);
        send_word(32'sd1, POS_MAX);
        send_word(POS_MAX, NEG_MAX);
    endtask

    // Bow point saturation both ways, widest relative speed, force limits at 0 and max.
    task automatic test_saturation();
        cfg_set(REG_BOW_VELOCITY, POS_MAX);
        cfg_set(REG_DOWNWARD_FORCE, 32'hFFFF_FFFF);
        send_word(32'sd0, 32'sd0);
        send_word(32'sd0, 32'sd0);
        send_word(32'sd0, 32'sd0);
        send_word(32'sd0, NEG_MAX);
        send_word(NEG_MAX, 32'sd0);
        send_word(-32'sd1, 32'sd0);
        cfg_set(REG_BOW_VELOCITY, NEG_MAX);
        cfg_set(REG_DOWNWARD_FORCE, 32'd0);
        send_word(-32'sd1, 32'sd0);
        send_word(32'sd0, 32'sd0);
        send_word(32'sd0, 32'sd0);
        send_word(32'sd0, NEG_MAX);
        send_word(32'sd5, -32'sd3);
    endtask

    // Phases of shaped random words under changing registers, with a disabled
    // stretch, a stretch without idling, and periodic drains.
    task automatic test_random_play();
        logic signed [WORD_W-1:0] pv;
        logic signed [WORD_W-1:0] pp;
        logic [WORD_W-1:0]        vel_word;
        logic [WORD_W-1:0]        df_word;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       vel_word = '0;
                1:       vel_word = $urandom;
                default: vel_word = $urandom_range(0, 1 << 18) - (1 << 17);
            endcase
            case ($urandom_range(0, 5))
                0:       df_word = 32'h0001_0000;
                1:       df_word = $urandom;
                2:       df_word = '0;
                default: df_word = $urandom_range(1, 1 << 20);
            endcase
            cfg_set(REG_BOW_VELOCITY, vel_word);
            cfg_set(REG_DOWNWARD_FORCE, df_word);
            if (phase == 6)
            begin
                cfg_set(REG_BOW_ENABLE, 32'd0);
                for (int n = 0; n < 15; n++)
                begin
                    shaped_word(pv, pp);
                    send_word(pv, pp);
                end
                cfg_set(REG_BOW_ENABLE, 32'd1);
            end
            no_idle = (phase == 4);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                shaped_word(pv, pp);
                send_word(pv, pp);
                if (n % 30 == 29)
                    wait_results_done();
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        bow_on     = 1'b0;
        bow_vel    = '0;
        push_force = DF_W'(FIX_ONE);
        slip_now   = 1'b0;
        bow_pos    = '0;
        held_force = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_drop();
        test_stick_slip_edges();
        test_saturation();
        test_random_play();

        // Drain, then give any stray word time to show up.
        wait_results_done();
        repeat (LATENCY_PAD) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
